// ===== hw/rtl/max_flow_dfs_augment_defines.svh =====
// Assertion helpers shared by the checker.
`ifndef MAX_FLOW_DFS_AUGMENT_DEFINES_SVH
`define MAX_FLOW_DFS_AUGMENT_DEFINES_SVH

// Property that must hold at every edge out of reset.
`define MFDA_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Antecedent this cycle implies consequent on the next edge.
`define MFDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mfda_pkg.sv =====
package mfda_pkg;

  localparam int unsigned NodeW    = 10;
  localparam int unsigned MaxNodes = 1024;
  localparam int unsigned ArcAw    = 12;   // arc table address
  localparam int unsigned ArcRefW  = 13;   // arc reference incl. "none"
  localparam int unsigned TopW     = 11;   // stack depth 0..MaxNodes
  localparam int unsigned FlowW    = 17;
  localparam int unsigned BnW      = 14;
  localparam int unsigned CapW     = 16;

  localparam logic [ArcRefW-1:0] ArcNone  = 13'd4096;
  localparam logic [ArcRefW-1:0] ArcLimit = 13'd4094;  // last count that still fits an edge
  localparam logic [BnW-1:0]     StartBn  = 14'd10000;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  typedef logic [4:0] cmd_t;

  localparam cmd_t CMD_NOP     = 5'd0;
  localparam cmd_t CMD_CAPTURE = 5'd1;
  localparam cmd_t CMD_CLRH    = 5'd2;
  localparam cmd_t CMD_IDLE    = 5'd3;
  localparam cmd_t CMD_DISP    = 5'd4;
  localparam cmd_t CMD_FULL    = 5'd5;
  localparam cmd_t CMD_L0      = 5'd6;
  localparam cmd_t CMD_L1      = 5'd7;
  localparam cmd_t CMD_L2      = 5'd8;
  localparam cmd_t CMD_L3      = 5'd9;
  localparam cmd_t CMD_VCLR    = 5'd10;
  localparam cmd_t CMD_SINIT   = 5'd11;
  localparam cmd_t CMD_PRD     = 5'd12;
  localparam cmd_t CMD_PWR     = 5'd13;
  localparam cmd_t CMD_SCAN    = 5'd14;
  localparam cmd_t CMD_SCAND   = 5'd15;
  localparam cmd_t CMD_VRD     = 5'd16;
  localparam cmd_t CMD_VD      = 5'd17;
  localparam cmd_t CMD_ADV     = 5'd18;
  localparam cmd_t CMD_POP     = 5'd19;
  localparam cmd_t CMD_POPLD   = 5'd20;
  localparam cmd_t CMD_POPWR   = 5'd21;
  localparam cmd_t CMD_AINIT   = 5'd22;
  localparam cmd_t CMD_ARD     = 5'd23;
  localparam cmd_t CMD_AE      = 5'd24;
  localparam cmd_t CMD_AW1     = 5'd25;
  localparam cmd_t CMD_AW2     = 5'd26;
  localparam cmd_t CMD_ADD     = 5'd27;
  localparam cmd_t CMD_RDI     = 5'd28;
  localparam cmd_t CMD_RESR    = 5'd29;
  localparam cmd_t CMD_RESD    = 5'd30;

  typedef struct packed {
    logic [1:0] op;
    logic       arc_full;
    logic       nc_one;
    logic       sweep_last;
    logic       a_none;
    logic       top_one;
    logic       res_pos;
    logic       hit_sink;
    logic       push_ok;
    logic       aug_last;
    logic       out_free;
  } status_t;

endpackage

// ===== hw/rtl/mfda_ctrl.sv =====
module mfda_ctrl
  import mfda_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    in_stall_o
);

  cmd_t state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      CMD_CLRH:  if (status_i.sweep_last) state_d = CMD_IDLE;
      CMD_IDLE:  if (in_valid_i) state_d = CMD_DISP;
      CMD_DISP: begin
        case (status_i.op)
          OP_LOAD: state_d = status_i.arc_full ? CMD_FULL : CMD_L0;
          OP_RUN:  state_d = status_i.nc_one ? CMD_RESR : CMD_VCLR;
          OP_READ: state_d = CMD_RDI;
          default: state_d = CMD_IDLE;
        endcase
      end
      CMD_FULL:  state_d = CMD_IDLE;
      CMD_L0:    state_d = CMD_L1;
      CMD_L1:    state_d = CMD_L2;
      CMD_L2:    state_d = CMD_L3;
      CMD_L3:    state_d = CMD_IDLE;
      CMD_VCLR:  if (status_i.sweep_last) state_d = CMD_SINIT;
      CMD_SINIT: state_d = CMD_PRD;
      CMD_PRD:   state_d = CMD_PWR;
      CMD_PWR:   state_d = CMD_SCAN;
      CMD_SCAN: begin
        if (status_i.a_none) state_d = status_i.top_one ? CMD_RESR : CMD_POP;
        else                 state_d = CMD_SCAND;
      end
      CMD_SCAND: begin
        if (status_i.res_pos) state_d = status_i.hit_sink ? CMD_AINIT : CMD_VRD;
        else                  state_d = CMD_ADV;
      end
      CMD_VRD:   state_d = CMD_VD;
      CMD_VD:    state_d = status_i.push_ok ? CMD_PRD : CMD_ADV;
      CMD_ADV:   state_d = CMD_SCAN;
      CMD_POP:   state_d = CMD_POPLD;
      CMD_POPLD: state_d = CMD_POPWR;
      CMD_POPWR: state_d = CMD_SCAN;
      CMD_AINIT: state_d = CMD_ARD;
      CMD_ARD:   state_d = CMD_AE;
      CMD_AE:    state_d = CMD_AW1;
      CMD_AW1:   state_d = CMD_AW2;
      CMD_AW2:   state_d = status_i.aug_last ? CMD_ADD : CMD_ARD;
      CMD_ADD:   state_d = CMD_VCLR;
      CMD_RDI:   state_d = CMD_RESD;
      CMD_RESR,
      CMD_RESD:  if (status_i.out_free) state_d = CMD_IDLE;
      default:   state_d = CMD_CLRH;
    endcase
  end

  always_comb begin
    case (state_q)
      CMD_IDLE:  cmd_o = in_valid_i ? CMD_CAPTURE : CMD_NOP;
      CMD_DISP,
      CMD_VD:    cmd_o = CMD_NOP;
      CMD_RESR,
      CMD_RESD:  cmd_o = status_i.out_free ? state_q : CMD_NOP;
      default:   cmd_o = state_q;
    endcase
  end

  assign in_stall_o = (state_q != CMD_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CMD_CLRH;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/mfda_dp.sv =====
module mfda_dp
  import mfda_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  input  logic                    cfg_valid_i,
  input  logic [NodeW-1:0]        cfg_data_i,
  input  logic [1:0]              operation_i,
  input  logic [NodeW-1:0]        from_node_i,
  input  logic [NodeW-1:0]        to_node_i,
  input  logic [CapW-1:0]         capacity_i,
  input  logic [10:0]             edge_index_i,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output logic [31:0]             total_flow_o,
  output logic signed [FlowW-1:0] edge_flow_o,
  output logic                    table_full_o
);

  // ---- storage ----
  logic [NodeW-1:0]   tgt_mem   [4096];
  logic [CapW-1:0]    cap_mem   [4096];
  logic [FlowW-1:0]   flow_mem  [4096];
  logic [ArcRefW-1:0] next_mem  [4096];
  logic [ArcRefW-1:0] first_mem [MaxNodes];
  logic [ArcAw-1:0]   last_mem  [MaxNodes];
  logic               vis_mem   [MaxNodes];
  logic [ArcRefW-1:0] sarc_mem  [MaxNodes];
  logic [BnW-1:0]     sbn_mem   [MaxNodes];

  logic [NodeW-1:0]   tgt_rd;
  logic [CapW-1:0]    cap_rd;
  logic [FlowW-1:0]   flow_rd;
  logic [ArcRefW-1:0] next_rd, first_rd, sarc_rd;
  logic [ArcAw-1:0]   last_rd;
  logic               vis_rd;
  logic [BnW-1:0]     sbn_rd;

  // ---- registers ----
  logic [1:0]         op_q;
  logic [NodeW-1:0]   a_node_q, b_node_q, nc_q, v_q;
  logic [CapW-1:0]    cap_q;
  logic [10:0]        k_q;
  logic [ArcRefW-1:0] arc_cnt_q, arc_cnt_d, a_q, nxt_q, e_q;
  logic [31:0]        sum_q;
  logic               ovf_q;
  logic [NodeW-1:0]   sw_q;
  logic [TopW-1:0]    top_q, i_q;
  logic [BnW-1:0]     fbn_q, pbn_q;
  logic               out_valid_q;

  // ---- port controls ----
  logic               arc_we, next_we, first_we, last_we, vis_we, sarc_we, sbn_we, flow_we;
  logic [ArcAw-1:0]   arc_wa, next_wa, flow_wa, arc_ra, flow_ra, next_ra;
  logic [NodeW-1:0]   tgt_wd;
  logic [ArcRefW-1:0] next_wd, first_wd, sarc_wd;
  logic [ArcAw-1:0]   last_wd;
  logic [FlowW-1:0]   flow_wd;
  logic               vis_wd;
  logic [NodeW-1:0]   node_wa, node_ra, vis_a, stk_wa, stk_ra;
  logic               arc_re, flow_re, next_re, node_re, vis_re, stk_re;

  logic [ArcAw-1:0]   c_arc, c_arc1;
  logic signed [FlowW:0] res;
  logic [BnW-1:0]     nb;
  logic [FlowW-1:0]   bn_ext;
  logic [TopW-1:0]    top_m1, top_m2;

  assign c_arc  = arc_cnt_q[ArcAw-1:0];
  assign c_arc1 = c_arc + ArcAw'(1);
  assign top_m1 = top_q - TopW'(1);
  assign top_m2 = top_q - TopW'(2);
  assign bn_ext = FlowW'(pbn_q);

  // residual of the scanned arc and the narrowed bottleneck
  assign res = $signed({2'b00, cap_rd}) - $signed({flow_rd[FlowW-1], flow_rd});
  assign nb  = (res < $signed({4'b0000, fbn_q})) ? res[BnW-1:0] : fbn_q;

  always_comb begin
    arc_we = 1'b0; next_we = 1'b0; first_we = 1'b0; last_we = 1'b0;
    vis_we = 1'b0; sarc_we = 1'b0; sbn_we = 1'b0; flow_we = 1'b0;
    arc_wa = c_arc; next_wa = c_arc; flow_wa = c_arc;
    arc_ra = a_q[ArcAw-1:0]; flow_ra = a_q[ArcAw-1:0]; next_ra = a_q[ArcAw-1:0];
    tgt_wd = b_node_q; next_wd = ArcNone; first_wd = ArcNone; sarc_wd = first_rd;
    last_wd = c_arc; flow_wd = '0; vis_wd = 1'b0;
    node_wa = a_node_q; node_ra = a_node_q; vis_a = v_q;
    stk_wa = top_q[NodeW-1:0]; stk_ra = top_m2[NodeW-1:0];
    arc_re = 1'b0; flow_re = 1'b0; next_re = 1'b0; node_re = 1'b0;
    vis_re = 1'b0; stk_re = 1'b0;
    case (cmd_i)
      CMD_CLRH: begin
        first_we = 1'b1; node_wa = sw_q;
      end
      CMD_L0, CMD_L2: begin
        arc_we = 1'b1; flow_we = 1'b1; next_we = 1'b1; node_re = 1'b1;
        if (cmd_i == CMD_L2) begin
          arc_wa = c_arc1; flow_wa = c_arc1; next_wa = c_arc1;
          tgt_wd = a_node_q; node_ra = b_node_q;
        end
      end
      CMD_L1, CMD_L3: begin
        // append to the tail node's list (L1) or the head node's list (L3)
        last_we = 1'b1;
        if (cmd_i == CMD_L3) begin
          node_wa = b_node_q; last_wd = c_arc1;
        end
        if (first_rd[ArcRefW-1]) begin
          first_we = 1'b1; first_wd = {1'b0, last_wd};
        end else begin
          next_we = 1'b1; next_wa = last_rd; next_wd = {1'b0, last_wd};
        end
      end
      CMD_VCLR: begin
        vis_we = 1'b1; vis_a = sw_q;
      end
      CMD_PRD: begin
        node_re = 1'b1; node_ra = v_q;
      end
      CMD_PWR: begin
        vis_we = 1'b1; vis_wd = 1'b1; sarc_we = 1'b1; sbn_we = 1'b1;
      end
      CMD_SCAN: begin
        arc_re = 1'b1; flow_re = 1'b1; next_re = 1'b1;
      end
      CMD_VRD: vis_re = 1'b1;
      CMD_ADV: begin
        sarc_we = 1'b1; stk_wa = top_m1[NodeW-1:0]; sarc_wd = nxt_q;
      end
      CMD_POP: stk_re = 1'b1;
      CMD_POPLD: begin
        next_re = 1'b1; next_ra = sarc_rd[ArcAw-1:0];
      end
      CMD_POPWR: begin
        sarc_we = 1'b1; stk_wa = top_m1[NodeW-1:0]; sarc_wd = next_rd;
      end
      CMD_ARD: begin
        stk_re = 1'b1; stk_ra = i_q[NodeW-1:0];
      end
      CMD_AE: begin
        flow_re = 1'b1; flow_ra = sarc_rd[ArcAw-1:0];
      end
      CMD_AW1: begin
        flow_we = 1'b1; flow_wa = e_q[ArcAw-1:0]; flow_wd = flow_rd + bn_ext;
        flow_re = 1'b1; flow_ra = e_q[ArcAw-1:0] ^ ArcAw'(1);
      end
      CMD_AW2: begin
        flow_we = 1'b1; flow_wa = e_q[ArcAw-1:0] ^ ArcAw'(1); flow_wd = flow_rd - bn_ext;
      end
      CMD_RDI: begin
        flow_re = 1'b1; flow_ra = {k_q, 1'b0};
      end
      default: ;
    endcase
  end

  // ---- memories ----
  always_ff @(posedge clk_i) begin
    if (arc_we) begin
      tgt_mem[arc_wa] <= tgt_wd;
      cap_mem[arc_wa] <= cap_q;
    end
    if (arc_re) begin
      tgt_rd <= tgt_mem[arc_ra];
      cap_rd <= cap_mem[arc_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_we) flow_mem[flow_wa] <= flow_wd;
    if (flow_re) flow_rd <= flow_mem[flow_ra];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (next_re) next_rd <= next_mem[next_ra];
  end

  always_ff @(posedge clk_i) begin
    if (first_we) first_mem[node_wa] <= first_wd;
    if (node_re)  first_rd <= first_mem[node_ra];
  end

  always_ff @(posedge clk_i) begin
    if (last_we) last_mem[node_wa] <= last_wd;
    if (node_re) last_rd <= last_mem[node_ra];
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) vis_mem[vis_a] <= vis_wd;
    if (vis_re) vis_rd <= vis_mem[vis_a];
  end

  always_ff @(posedge clk_i) begin
    if (sarc_we) sarc_mem[stk_wa] <= sarc_wd;
    if (stk_re)  sarc_rd <= sarc_mem[stk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sbn_we) sbn_mem[stk_wa] <= pbn_q;
    if (stk_re) sbn_rd <= sbn_mem[stk_ra];
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_CAPTURE) begin
      op_q     <= operation_i;
      a_node_q <= from_node_i;
      b_node_q <= to_node_i;
      cap_q    <= capacity_i;
      k_q      <= edge_index_i;
    end
    case (cmd_i)
      CMD_SINIT: begin
        v_q <= NodeW'(1); pbn_q <= StartBn;
      end
      CMD_PWR: begin
        a_q <= first_rd; fbn_q <= pbn_q;
      end
      CMD_SCAND: begin
        v_q <= tgt_rd; nxt_q <= next_rd; pbn_q <= nb;
      end
      CMD_ADV:   a_q <= nxt_q;
      CMD_POPLD: fbn_q <= sbn_rd;
      CMD_POPWR: a_q <= next_rd;
      CMD_AE:    e_q <= sarc_rd;
      default: ;
    endcase
    if (cmd_i == CMD_RESR || cmd_i == CMD_RESD) begin
      total_flow_o <= (cmd_i == CMD_RESR) ? sum_q : '0;
      edge_flow_o  <= (cmd_i == CMD_RESD && ({k_q, 1'b0} < arc_cnt_q)) ? flow_rd : '0;
      table_full_o <= ovf_q;
    end
  end

  // ---- control registers ----
  always_comb begin
    arc_cnt_d = arc_cnt_q;
    if (cmd_i == CMD_L3) arc_cnt_d = arc_cnt_q + ArcRefW'(2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q        <= NodeW'(2);
      arc_cnt_q   <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      sw_q        <= '0;
      top_q       <= '0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) nc_q <= cfg_data_i;
      arc_cnt_q <= arc_cnt_d;
      if (cmd_i == CMD_FULL) ovf_q <= 1'b1;
      if (cmd_i == CMD_ADD)  sum_q <= sum_q + 32'(pbn_q);
      if (cmd_i == CMD_CLRH || cmd_i == CMD_VCLR) sw_q <= sw_q + NodeW'(1);
      case (cmd_i)
        CMD_SINIT: top_q <= '0;
        CMD_PWR:   top_q <= top_q + TopW'(1);
        CMD_POP:   top_q <= top_m1;
        default: ;
      endcase
      if (cmd_i == CMD_AINIT)    i_q <= '0;
      else if (cmd_i == CMD_AW2) i_q <= i_q + TopW'(1);
      if (cmd_i == CMD_RESR || cmd_i == CMD_RESD) out_valid_q <= 1'b1;
      else if (!out_stall_i)                      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    status_o.op         = op_q;
    status_o.arc_full   = (arc_cnt_q > ArcLimit);
    status_o.nc_one     = (nc_q == NodeW'(1));
    status_o.sweep_last = (sw_q == NodeW'(MaxNodes - 1));
    status_o.a_none     = a_q[ArcRefW-1];
    status_o.top_one    = (top_q == TopW'(1));
    status_o.res_pos    = !res[FlowW] && (res != '0);
    status_o.hit_sink   = (tgt_rd == nc_q);
    status_o.push_ok    = !vis_rd && !top_q[TopW-1];
    status_o.aug_last   = ((i_q + TopW'(1)) == top_q);
    status_o.out_free   = !out_valid_q || !out_stall_i;
  end

endmodule

// ===== hw/rtl/max_flow_dfs_augment.sv =====
// Operation: load writes the forward and reverse arcs and links each into its node's list
//   (dropped when the arc table is full); read fetches the flow of the edge's forward
//   arc; run is data dependent: each search clears visited marks, pushes the source,
//   skips arcs with no residual or to visited nodes, pushes, pops, then augments.
// Throughput: one beat in work at a time; a result may wait in the output register.
// Reset: asynchronous active low; a sweep over all nodes empties the node lists while the input stalls.
module max_flow_dfs_augment
  import mfda_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration: sink node number
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [NodeW-1:0]        cfg_data_i,
  // input beats
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              operation_i,
  input  logic [NodeW-1:0]        from_node_i,
  input  logic [NodeW-1:0]        to_node_i,
  input  logic [CapW-1:0]         capacity_i,
  input  logic [10:0]             edge_index_i,
  // result beats
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [31:0]             total_flow_o,
  output logic signed [FlowW-1:0] edge_flow_o,
  output logic                    table_full_o
);

  cmd_t    cmd;
  status_t status;

  // The user keeps writes to idle (the block does not enforce it); the register takes any write.
  assign cfg_ready_o = 1'b1;

  // Sequencer: walks load linking, the DFS stack machine, augmentation and
  // result hand-off; it looks only at in_valid_i and the status flags from the datapath.
  mfda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // Datapath: arc table, node lists, visited marks, explicit DFS stack and
  // the output register.
  mfda_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .operation_i  (operation_i),
    .from_node_i  (from_node_i),
    .to_node_i    (to_node_i),
    .capacity_i   (capacity_i),
    .edge_index_i (edge_index_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .total_flow_o (total_flow_o),
    .edge_flow_o  (edge_flow_o),
    .table_full_o (table_full_o)
  );

endmodule

// ===== hw/rtl/mfda_chk.sv =====
`include "max_flow_dfs_augment_defines.svh"

module mfda_chk
  import mfda_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    cfg_valid_i,
  input logic                    cfg_ready_o,
  input logic [NodeW-1:0]        cfg_data_i,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic [1:0]              operation_i,
  input logic [NodeW-1:0]        from_node_i,
  input logic [NodeW-1:0]        to_node_i,
  input logic [CapW-1:0]         capacity_i,
  input logic [10:0]             edge_index_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [31:0]             total_flow_o,
  input logic signed [FlowW-1:0] edge_flow_o,
  input logic                    table_full_o
);

  // stalled result beat holds
  `MFDA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(total_flow_o) && $stable(edge_flow_o) && $stable(table_full_o), "stalled result changed")

  // a result is either a run total or an edge read, never both
  `MFDA_ASSERT_ALWAYS(a_one_kind, !out_valid_o || total_flow_o == '0 || edge_flow_o == '0, "mixed result")

  // the dropped-load flag never falls back
  `MFDA_ASSERT_NEXT(a_full_sticky, table_full_o == 1'b1, table_full_o == 1'b1, "table_full cleared")

endmodule

bind max_flow_dfs_augment mfda_chk u_mfda_chk (.*);
